// ===== sv/sbpk_pkg.sv =====
// sbpk_pkg: shared types, codes and helpers of the sorted block prefix key encoder
// no dependencies; imported by the top level, sbpk_hdr and sbpk_chk

package sbpk_pkg;

	localparam int IN_W      = 32;	// s_tdata width
	localparam int OUT_W     = 40;	// m_tdata width
	localparam int IV_W      = 11;	// restart interval register
	localparam int ENT_W     = 10;	// entries since last restart
	localparam int KLEN_W    = 7;
	localparam int VLEN_W    = 16;
	localparam int FLD_W     = 16;	// header field width before varint coding
	localparam int HBUF_W    = 80;	// up to ten header bytes
	localparam int HCNT_W    = 4;
	localparam int WORD_W    = 32;
	localparam int CNT_W     = 3;

	localparam logic [IV_W-1:0]   IV_RESET   = 11'd16;
	localparam logic [IV_W-1:0]   IV_MAX     = 11'd1024;
	localparam logic [7:0]        VARINT_CONT = 8'h80;
	localparam logic [FLD_W-1:0]  VARINT_TWO_LIMIT = 16'h4000;
	localparam logic [CNT_W-1:0]  WORD_BYTES = 3'd4;
	localparam logic [HCNT_W-1:0] WORD_BYTES_H = 4'd4;

	typedef enum logic [1:0] {
		CMD_KEY,
		CMD_VAL,
		CMD_FIN,
		CMD_NOP
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_KEY,
		S_VAL,
		S_HDR,
		S_FOOT,
		S_CNT
	} state_t;

	typedef enum logic [1:0] {
		HM_NONE,
		HM_BYTE,
		HM_HDR,
		HM_HDR_DATA
	} hdr_mode_t;

	typedef struct packed {
		hdr_mode_t        mode;
		logic [FLD_W-1:0] f0;
		logic [FLD_W-1:0] f1;
		logic [FLD_W-1:0] f2;
		logic [7:0]       data;
	} hdr_req_t;

	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  len;
	} varint_t;

	typedef struct packed {
		logic              push;
		logic [WORD_W-1:0] bytes;
		logic [CNT_W-1:0]  cnt;
		logic              last;
		logic              ovf;
	} push_t;

	// little-endian base-128 coding of a 16-bit value, one to three bytes
	function automatic varint_t varint16(input logic [FLD_W-1:0] v);
		varint_t r;
		if (v < FLD_W'(VARINT_CONT)) begin
			r.bytes = {16'h0000, v[7:0]};
			r.len   = 2'd1;
		end else if (v < VARINT_TWO_LIMIT) begin
			r.bytes = {8'h00, 1'b0, v[13:7], VARINT_CONT | {1'b0, v[6:0]}};
			r.len   = 2'd2;
		end else begin
			r.bytes = {6'b000000, v[15:14], VARINT_CONT | {1'b0, v[13:7]},
				VARINT_CONT | {1'b0, v[6:0]}};
			r.len   = 2'd3;
		end
		return r;
	endfunction

endpackage

// ===== sv/sorted_block_prefix_key_encoder.sv =====
// sorted_block_prefix_key_encoder: top level of the prefix-compressed data block builder
// depends on sbpk_pkg, sbpk_ram (key and restart stores) and sbpk_hdr (header packer)
//
// usage
//   s_* stream carries one command item: key byte, value byte or finish.
//   m_* stream carries results of up to four bytes each; m_tlast marks the
//   final result caused by one input item, m_tuser flags a full restart store.
//   cfg_* writes the restart interval; write it only while the block is idle.
// sequencing
//   value byte: the value state pushes its one-byte result once the output register is free.
//   key byte: the key state pushes up to four bytes when the output register is free, and
//   the header state the rest one word at a time (a header is at most three words).
//   the key byte is read from the key store at accept and compared in the next cycle.
//   finish: one offset word per cycle while the output register is free (one zero offset
//   for an empty block), streamed from the registered restart store, then the restart count.
// reset
//   all counters clear and the interval returns to 16; the two stores are
//   not cleared, and no word read from them is used before it is written.
// back-pressure
//   results wait in the output register; the block takes the next input
//   item meanwhile, and holds further results until m_tready frees it.

module sorted_block_prefix_key_encoder
	import sbpk_pkg::*;
#(
	parameter int MAX_KEY_LEN  = 64,
	parameter int MAX_RESTARTS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	// input items
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,	// data[7:0], key_length[14:8], value_length[30:15], zero
	input  logic [1:0]       s_tuser,	// command[1:0]
	// result items
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,	// out_bytes[31:0], byte_count[34:32], zero
	output logic             m_tuser,	// overflow
	output logic             m_tlast,	// last_of_run
	// restart interval write
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IV_W-1:0]  cfg_data
);

	localparam int LW  = $clog2(MAX_KEY_LEN + 1);	// key length values
	localparam int PW  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;	// key position
	localparam int TW  = $clog2(MAX_RESTARTS + 1);	// restart count
	localparam int RAW = (MAX_RESTARTS > 1) ? $clog2(MAX_RESTARTS) : 1;

	state_t state_q, state_d;
	push_t  po;

	// block state
	logic [PW-1:0]     key_pos_q;
	logic [LW-1:0]     prev_len_q;
	logic              prefix_q;
	logic [ENT_W-1:0]  entries_q;
	logic [TW-1:0]     total_q;
	logic [WORD_W-1:0] bytes_q;
	logic              ovf_q;
	logic [IV_W-1:0]   iv_q;

	// latched input item
	logic [7:0]        data_q;
	logic [KLEN_W-1:0] klen_q;
	logic [VLEN_W-1:0] vlen_q;

	// pending header words
	logic [HBUF_W-1:0] hbuf_q;
	logic [HCNT_W-1:0] hrem_q;
	logic [RAW-1:0]    fidx_q, fidx_d;

	// output register
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;
	logic              m_tlast_q;
	logic              m_tuser_q;

	logic              accept, can_push;
	cmd_t              cmd_in;
	logic [7:0]        key_rd;
	logic [WORD_W-1:0] off_rd;

	// key byte evaluation
	logic [LW-1:0]     len_k, p_k;
	logic              last_k, restart_k, match_k, full_k, ovf_k;
	logic [IV_W-1:0]   iv_c, ent_inc;
	logic [ENT_W-1:0]  entries_nx;
	hdr_req_t          hreq;
	logic [HBUF_W-1:0] hbuf;
	logic [HCNT_W-1:0] hlen;
	logic              foot_last;

	assign accept    = s_tvalid && s_tready;
	assign cmd_in    = cmd_t'(s_tuser);
	assign can_push  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign foot_last = (TW'(fidx_q) + TW'(1)) == total_q;

	// previous key store: the byte at this position is read and replaced
	// in the accept cycle; read-first gives the old byte for the compare
	sbpk_ram #(
		.WIDTH (8),
		.DEPTH (MAX_KEY_LEN)
	) u_key_ram (
		.clk   (clk),
		.we    (accept && cmd_in == CMD_KEY),
		.waddr (key_pos_q),
		.wdata (s_tdata[7:0]),
		.re    (accept && cmd_in == CMD_KEY),
		.raddr (key_pos_q),
		.rdata (key_rd)
	);

	// restart offsets: written in the key evaluation cycle; the read port always runs, but its
	// data is used only while the footer streams out, when no write happens
	sbpk_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_RESTARTS)
	) u_rst_ram (
		.clk   (clk),
		.we    (state_q == S_KEY && restart_k && !full_k),
		.waddr (RAW'(total_q)),
		.wdata (bytes_q),
		.re    (1'b1),
		.raddr (fidx_d),
		.rdata (off_rd)
	);

	sbpk_hdr u_hdr (
		.req  (hreq),
		.hbuf (hbuf),
		.hlen (hlen)
	);

	// key byte: effective length, restart and prefix match decisions
	always_comb begin
		if (int'(klen_q) > MAX_KEY_LEN) begin
			len_k = LW'(MAX_KEY_LEN);
		end else begin
			len_k = LW'(klen_q);
		end
		if (len_k == '0) begin
			len_k = LW'(1);
		end
		// key_pos_q stays below MAX_KEY_LEN, no clamp needed
		p_k = LW'(key_pos_q);
		if (p_k >= len_k) begin
			len_k = p_k + LW'(1);
		end
		last_k    = (len_k == p_k + LW'(1));
		restart_k = prefix_q && (p_k == '0) && (entries_q == '0);
		match_k   = (p_k < prev_len_q) && (data_q == key_rd);
		full_k    = (total_q >= TW'(MAX_RESTARTS));
		ovf_k     = ovf_q || (restart_k && full_k);

		hreq.mode = HM_BYTE;
		hreq.f0   = '0;
		hreq.f1   = FLD_W'(len_k);
		hreq.f2   = vlen_q;
		hreq.data = data_q;
		if (prefix_q) begin
			if (restart_k) begin
				hreq.mode = HM_HDR_DATA;
			end else if (match_k) begin
				// byte inside the shared prefix: nothing, or a header with no byte if the key ends here
				hreq.mode = last_k ? HM_HDR : HM_NONE;
				hreq.f0   = FLD_W'(len_k);
				hreq.f1   = '0;
			end else begin
				hreq.mode = HM_HDR_DATA;
				hreq.f0   = FLD_W'(p_k);
				hreq.f1   = FLD_W'(len_k - p_k);
			end
		end
	end

	// interval clamp and restart group counter
	always_comb begin
		if (iv_q == '0) begin
			iv_c = IV_W'(1);
		end else if (iv_q > IV_MAX) begin
			iv_c = IV_MAX;
		end else begin
			iv_c = iv_q;
		end
		ent_inc = {1'b0, entries_q} + IV_W'(1);
		if (ent_inc >= iv_c) begin
			entries_nx = '0;
		end else begin
			entries_nx = ent_inc[ENT_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_in)
						CMD_KEY: state_d = S_KEY;
						CMD_VAL: state_d = S_VAL;
						CMD_FIN: state_d = S_FOOT;
						CMD_NOP: state_d = S_IDLE;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_VAL: begin
				if (can_push) state_d = S_IDLE;
			end
			S_KEY: begin
				if (hlen == '0 || (can_push && hlen <= WORD_BYTES_H)) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_HDR;
				end
			end
			S_HDR: begin
				if (can_push && hrem_q <= WORD_BYTES_H) state_d = S_IDLE;
			end
			S_FOOT: begin
				if (can_push && (total_q == '0 || foot_last)) state_d = S_CNT;
			end
			S_CNT: begin
				if (can_push) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: input ready and the result pushed into the output register
	always_comb begin
		s_tready = 1'b0;
		po.push  = 1'b0;
		po.bytes = '0;
		po.cnt   = WORD_BYTES;
		po.last  = 1'b0;
		po.ovf   = ovf_q;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
			end
			S_VAL: begin
				po.push  = can_push;
				po.bytes = WORD_W'(data_q);
				po.cnt   = CNT_W'(1);
				po.last  = 1'b1;
			end
			S_KEY: begin
				po.push  = can_push && hlen != '0;
				po.bytes = hbuf[WORD_W-1:0];
				po.cnt   = (hlen >= WORD_BYTES_H) ? WORD_BYTES : hlen[CNT_W-1:0];
				po.last  = hlen <= WORD_BYTES_H;
				po.ovf   = ovf_k;
			end
			S_HDR: begin
				po.push  = can_push;
				po.bytes = hbuf_q[WORD_W-1:0];
				po.cnt   = (hrem_q >= WORD_BYTES_H) ? WORD_BYTES : hrem_q[CNT_W-1:0];
				po.last  = hrem_q <= WORD_BYTES_H;
			end
			S_FOOT: begin
				// empty block lists a single offset of zero
				po.push  = can_push;
				po.bytes = (total_q == '0) ? '0 : off_rd;
				po.last  = 1'b0;
			end
			S_CNT: begin
				po.push  = can_push;
				po.bytes = (total_q == '0) ? WORD_W'(1) : WORD_W'(total_q);
				po.last  = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// footer read index, presented to the store in the cycle before its data
	always_comb begin
		if (state_q == S_FOOT) begin
			fidx_d = (po.push && !foot_last) ? fidx_q + RAW'(1) : fidx_q;
		end else begin
			fidx_d = '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fidx_q     <= '0;
			iv_q       <= IV_RESET;
			m_tvalid_q <= 1'b0;
			key_pos_q  <= '0;
			prev_len_q <= '0;
			prefix_q   <= 1'b1;
			entries_q  <= '0;
			total_q    <= '0;
			bytes_q    <= '0;
			ovf_q      <= 1'b0;
			hrem_q     <= '0;
		end else begin
			state_q <= state_d;
			fidx_q  <= fidx_d;
			if (cfg_valid) begin
				iv_q <= cfg_data;
			end
			if (po.push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_VAL: begin
					if (po.push) bytes_q <= bytes_q + WORD_W'(1);
				end
				S_KEY: begin
					bytes_q <= bytes_q + WORD_W'(hlen);
					hrem_q  <= po.push ? hlen - WORD_BYTES_H : hlen;
					if (restart_k) begin
						if (full_k) begin
							ovf_q <= 1'b1;
						end else begin
							total_q <= total_q + TW'(1);
						end
					end
					if (last_k) begin
						prev_len_q <= len_k;
						key_pos_q  <= '0;
						prefix_q   <= 1'b1;
						entries_q  <= entries_nx;
					end else begin
						key_pos_q <= PW'(p_k + LW'(1));
						prefix_q  <= prefix_q && !restart_k && match_k;
					end
				end
				S_HDR: begin
					if (po.push) hrem_q <= hrem_q - WORD_BYTES_H;
				end
				S_CNT: begin
					// block done: start a fresh one, interval kept
					if (po.push) begin
						key_pos_q  <= '0;
						prev_len_q <= '0;
						prefix_q   <= 1'b1;
						entries_q  <= '0;
						total_q    <= '0;
						bytes_q    <= '0;
						ovf_q      <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= s_tdata[7:0];
			klen_q <= s_tdata[14:8];
			vlen_q <= s_tdata[30:15];
		end
		if (state_q == S_KEY) begin
			hbuf_q <= po.push ? (hbuf >> WORD_W) : hbuf;
		end else if (state_q == S_HDR && po.push) begin
			hbuf_q <= hbuf_q >> WORD_W;
		end
		if (po.push) begin
			m_tdata_q <= {(OUT_W - WORD_W - CNT_W)'(0), po.cnt, po.bytes};
			m_tlast_q <= po.last;
			m_tuser_q <= po.ovf;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== sv/sbpk_ram.sv =====
// sbpk_ram: simple dual-port synchronous ram, registered read, read-first
// no dependencies; used for the previous key and the restart offset stores

module sbpk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// same-address read returns the old word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/sbpk_hdr.sv =====
// sbpk_hdr: packs an entry header (three varints plus an optional key byte) or a lone
// key byte into a little-endian byte buffer; depends on sbpk_pkg

module sbpk_hdr
	import sbpk_pkg::*;
(
	input  hdr_req_t           req,
	output logic [HBUF_W-1:0]  hbuf,
	output logic [HCNT_W-1:0]  hlen
);

	varint_t            v0, v1, v2;
	logic [HCNT_W-1:0]  off1, off2, off3;

	always_comb begin
		v0   = varint16(req.f0);
		v1   = varint16(req.f1);
		v2   = varint16(req.f2);
		off1 = HCNT_W'(v0.len);
		off2 = off1 + HCNT_W'(v1.len);
		off3 = off2 + HCNT_W'(v2.len);
		hbuf = '0;
		hlen = '0;
		case (req.mode)
			HM_BYTE: begin
				hbuf = HBUF_W'(req.data);
				hlen = HCNT_W'(1);
			end
			HM_HDR, HM_HDR_DATA: begin
				hbuf = HBUF_W'(v0.bytes)
					| (HBUF_W'(v1.bytes) << {off1, 3'b000})
					| (HBUF_W'(v2.bytes) << {off2, 3'b000});
				hlen = off3;
				if (req.mode == HM_HDR_DATA) begin
					hbuf = hbuf | (HBUF_W'(req.data) << {off3, 3'b000});
					hlen = off3 + HCNT_W'(1);
				end
			end
			default: begin
				hbuf = '0;
				hlen = '0;
			end
		endcase
	end

endmodule

// ===== sv/sbpk_chk.sv =====
// sbpk_chk: port-level checks of the sorted block prefix key encoder
// depends on sbpk_pkg; bound to the top level at the end of this file

module sbpk_chk
	import sbpk_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [1:0]       s_tuser,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// one to four valid bytes, padding zero
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[34:32] != 3'd0 && m_tdata[34:32] <= WORD_BYTES
			&& m_tdata[OUT_W-1:35] == '0)
		else $error("bad byte count");

	// only the closing result of a run may be partial
	a_partial: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34:32] != WORD_BYTES |-> m_tlast)
		else $error("partial word before end of run");

	// one item at a time: after a real command the input closes
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != CMD_NOP |=> !s_tready)
		else $error("item taken while busy");

endmodule

bind sorted_block_prefix_key_encoder sbpk_chk u_sbpk_chk (.*);
